// ----- design/mroe_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix row operation engine: shared types and constants
// Operation codes, register map and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mroe_pkg;

	localparam int ELEM_W  = 32;
	localparam int ORDER_W = 4;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Q16.16 representation of 1.0
	localparam logic signed [ELEM_W-1:0] Q_ONE = 32'sd65536;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

	// Register index as seen at paddr[2]
	localparam logic [0:0] REG_ORDER_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		OP_SWAP  = 2'd0,
		OP_SCALE = 2'd1,
		OP_ADD   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic clr_en;
		logic load_item;
		logic start_cols;
		logic rd_a;
		logic rd_b;
		logic calc;
		logic wr_a;
		logic wr_b;
		logic col_adv;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic err;
		logic skip;
		logic is_read;
		logic is_swap;
		logic last_col;
	} sts_t;

endpackage

// ----- design/mroe_if.sv -----
// ----------------------------------------------------------------------------
// Matrix row operation engine: channel interfaces
// Valid/ready channels for the operation words and the result words.
// ----------------------------------------------------------------------------
interface mroe_in_if;
	logic                                  valid;
	logic                                  ready;
	mroe_pkg::op_t                         operation;
	logic [2:0]                            first_row;
	logic [2:0]                            second_row;
	logic [2:0]                            column_index;
	logic signed [mroe_pkg::ELEM_W-1:0]    scale_factor;

	modport source (output valid, operation, first_row, second_row, column_index,
		scale_factor, input ready);
	modport sink (input valid, operation, first_row, second_row, column_index,
		scale_factor, output ready);
endinterface

interface mroe_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mroe_pkg::ELEM_W-1:0]    element_value;
	logic                                  index_error;

	modport source (output valid, element_value, index_error, input ready);
	modport sink (input valid, element_value, index_error, output ready);
endinterface

// ----- design/mroe_ram.sv -----
// ----------------------------------------------------------------------------
// Matrix row operation engine: single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module mroe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/mroe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Matrix row operation engine: controller
// Sequences the clearing pass, the per-column read/compute/write steps and
// the hand-over of each result word to the output register.
// ----------------------------------------------------------------------------
module mroe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output mroe_pkg::cmd_t cmd,
	input  mroe_pkg::sts_t sts
);

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_START  = 9'b000000100,
		S_RD_A   = 9'b000001000,
		S_RD_B   = 9'b000010000,
		S_CALC   = 9'b000100000,
		S_WR_A   = 9'b001000000,
		S_WR_B   = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_START;
				end
			end
			S_START: begin
				cmd.start_cols = 1'b1;
				state_d        = sts.skip ? S_FINISH : S_RD_A;
			end
			S_RD_A: begin
				cmd.rd_a = 1'b1;
				state_d  = S_RD_B;
			end
			S_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = sts.is_read ? S_FINISH : S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_WR_A;
			end
			S_WR_A: begin
				cmd.wr_a = 1'b1;
				if (sts.is_swap) begin
					state_d = S_WR_B;
				end else begin
					cmd.col_adv = 1'b1;
					state_d     = sts.last_col ? S_FINISH : S_RD_A;
				end
			end
			S_WR_B: begin
				cmd.wr_b    = 1'b1;
				cmd.col_adv = 1'b1;
				state_d     = sts.last_col ? S_FINISH : S_RD_A;
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_START))
		else $error("accepted word did not start an operation");

	a_skip_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START && sts.skip) |=> (state_q == S_FINISH))
		else $error("skipped operation touched the store");

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR_A || state_q == S_WR_B) |-> !sts.is_read)
		else $error("read operation reached a write step");

	a_swap_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR_B && sts.last_col) |=> (state_q == S_FINISH))
		else $error("swap ran past the last column");

endmodule

// ----- design/mroe_dpath.sv -----
// ----------------------------------------------------------------------------
// Matrix row operation engine: datapath
// Holds the operation word, the matrix store, the column and clearing
// counters, the Q16.16 multiplier and the result register.
// ----------------------------------------------------------------------------
module mroe_dpath #(
	parameter int MAX_ORDER = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mroe_pkg::cmd_t                     cmd,
	output mroe_pkg::sts_t                     sts,
	input  logic [mroe_pkg::ORDER_W-1:0]       order_eff,
	input  mroe_pkg::op_t                      operation,
	input  logic [2:0]                         first_row,
	input  logic [2:0]                         second_row,
	input  logic [2:0]                         column_index,
	input  logic signed [mroe_pkg::ELEM_W-1:0] scale_factor,
	output logic signed [mroe_pkg::ELEM_W-1:0] element_value,
	output logic                               index_error
);

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_ORDER);
	localparam int OW    = mroe_pkg::ORDER_W;
	localparam int EW    = mroe_pkg::ELEM_W;
	localparam logic [RW-1:0] LAST_IDX = RW'(MAX_ORDER - 1);

	mroe_pkg::op_t          op_q;
	logic [2:0]             r1_q, r2_q, cidx_q;
	logic signed [EW-1:0]   k_q;
	logic [OW-1:0]          col_q;
	logic [RW-1:0]          clr_row_q, clr_col_q;
	logic signed [EW-1:0]   a_q, b_q;
	logic signed [2*EW-1:0] prod_s1;
	logic signed [EW-1:0]   elem_q;
	logic                   err_q;

	logic                   r1_ok, r2_ok, c_ok, err;
	logic [2:0]             item_row;
	logic [OW-1:0]          item_col;
	logic [AW-1:0]          item_addr, clr_addr, mem_addr;
	logic                   mem_we;
	logic [EW-1:0]          mem_wdata, mem_rdata;
	logic signed [EW+16:0]  wide;
	logic signed [EW-1:0]   wr_a_data;

	function automatic logic signed [EW-1:0] sat_elem(input logic signed [EW+16:0] v);
		logic signed [EW-1:0] r;
		if (v[EW+16:EW-1] == '0 || v[EW+16:EW-1] == '1) begin
			r = v[EW-1:0];
		end else if (v[EW+16]) begin
			r = {1'b1, {(EW-1){1'b0}}};
		end else begin
			r = {1'b0, {(EW-1){1'b1}}};
		end
		return r;
	endfunction

	// Index checks against the order in use
	assign r1_ok = ({1'b0, r1_q} < order_eff);
	assign r2_ok = ({1'b0, r2_q} < order_eff);
	assign c_ok  = ({1'b0, cidx_q} < order_eff);

	always_comb begin
		case (op_q)
			mroe_pkg::OP_SWAP, mroe_pkg::OP_ADD: err = !(r1_ok && r2_ok);
			mroe_pkg::OP_SCALE:                  err = !r1_ok;
			default:                             err = !(r1_ok && c_ok);
		endcase
	end

	assign sts.err      = err;
	assign sts.is_read  = (op_q == mroe_pkg::OP_READ);
	assign sts.is_swap  = (op_q == mroe_pkg::OP_SWAP);
	// A zero factor, or a swap of a row with itself, leaves the store as it is.
	assign sts.skip     = err || (sts.is_swap && r1_q == r2_q) ||
		((op_q == mroe_pkg::OP_SCALE || op_q == mroe_pkg::OP_ADD) && k_q == '0);
	assign sts.last_col = ((5'(col_q) + 5'd1) == 5'(order_eff));
	assign sts.clr_done = (clr_row_q == LAST_IDX) && (clr_col_q == LAST_IDX);

	// Address selection for the single memory port
	always_comb begin
		item_row = r1_q;
		item_col = col_q;
		if (cmd.rd_a) begin
			item_row = (op_q == mroe_pkg::OP_ADD) ? r2_q : r1_q;
			item_col = (op_q == mroe_pkg::OP_READ) ? {1'b0, cidx_q} : col_q;
		end else if (cmd.rd_b) begin
			item_row = (op_q == mroe_pkg::OP_SWAP) ? r2_q : r1_q;
		end else if (cmd.wr_b) begin
			item_row = r2_q;
		end
	end

	assign item_addr = AW'(32'(item_row) * MAX_ORDER + 32'(item_col));
	assign clr_addr  = AW'(32'(clr_row_q) * MAX_ORDER + 32'(clr_col_q));
	assign mem_addr  = cmd.clr_en ? clr_addr : item_addr;
	assign mem_we    = cmd.clr_en || cmd.wr_a || cmd.wr_b;

	// Product is floored by dropping its sixteen fraction bits.
	always_comb begin
		if (op_q == mroe_pkg::OP_ADD) begin
			wide = (EW+17)'(b_q) + (EW+17)'($signed(prod_s1[2*EW-1:16]));
		end else begin
			wide = (EW+17)'($signed(prod_s1[2*EW-1:16]));
		end
		wr_a_data = sts.is_swap ? b_q : sat_elem(wide);
	end

	always_comb begin
		if (cmd.clr_en) begin
			mem_wdata = (clr_row_q == clr_col_q) ? mroe_pkg::Q_ONE : '0;
		end else if (cmd.wr_b) begin
			mem_wdata = a_q;
		end else begin
			mem_wdata = wr_a_data;
		end
	end

	mroe_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			clr_row_q <= '0;
			clr_col_q <= '0;
		end else begin
			if (cmd.start_cols) begin
				col_q <= '0;
			end else if (cmd.col_adv) begin
				col_q <= col_q + 1'b1;
			end
			if (cmd.clr_en) begin
				if (clr_col_q == LAST_IDX) begin
					clr_col_q <= '0;
					clr_row_q <= clr_row_q + 1'b1;
				end else begin
					clr_col_q <= clr_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= operation;
			r1_q   <= first_row;
			r2_q   <= second_row;
			cidx_q <= column_index;
			k_q    <= scale_factor;
		end
		if (cmd.rd_b) begin
			a_q <= mem_rdata;
		end
		if (cmd.calc) begin
			b_q     <= mem_rdata;
			prod_s1 <= a_q * k_q;
		end
		if (cmd.out_load) begin
			elem_q <= (sts.is_read && !err) ? a_q : '0;
			err_q  <= err;
		end
	end

	assign element_value = elem_q;
	assign index_error   = err_q;

endmodule

// ----- design/matrix_row_operation_engine.sv -----
// ----------------------------------------------------------------------------
// Matrix row operation engine
// Applies elementary row operations to a square Q16.16 matrix store.
// ----------------------------------------------------------------------------
// Operation words arrive on in_ch (valid/ready) and each one gives exactly
// one result word on out_ch: the element read, or zero, and an index error
// flag. The order in use is written over the APB port at address 0.
// After reset the store is loaded with the identity matrix by a clearing
// pass over all MAX_ORDER*MAX_ORDER entries (64 at the default), in which
// no operation word is taken; register writes are accepted throughout.
// One word is processed at a time. A read passes the start step and the
// read steps before its element is loaded into the result register; scale
// and add run two reads, a compute and a write for each column up to the
// order in use, and a swap a second write as well. Errored and no-effect
// words go from the start step straight to the final step. The next word
// is taken once the core is back in idle. The single memory port sets the
// pace: each column needs two reads and one write, or two writes for a swap.
// The result register frees the core: a new word is taken while a result
// still waits, and the core stalls in its final step only when it has a
// further result ready and the receiver holds ready low.
// ----------------------------------------------------------------------------
module matrix_row_operation_engine #(
	parameter int MAX_ORDER = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mroe_pkg::PADDR_W-1:0] paddr,
	input  logic [mroe_pkg::PDATA_W-1:0] pwdata,
	output logic [mroe_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	mroe_in_if.sink                      in_ch,
	mroe_out_if.source                   out_ch
);

	localparam int OW = mroe_pkg::ORDER_W;
	localparam logic [OW-1:0] MAX_ORD4 = (MAX_ORDER > 15) ? 4'd15 : OW'(MAX_ORDER);

	logic [OW-1:0]  order_q;
	logic [OW-1:0]  order_eff;
	logic           cfg_wr;
	mroe_pkg::cmd_t cmd;
	mroe_pkg::sts_t sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= mroe_pkg::ORDER_RESET;
		end else if (cfg_wr && paddr[2:2] == mroe_pkg::REG_ORDER_IN_USE) begin
			order_q <= pwdata[OW-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2:2])
			mroe_pkg::REG_ORDER_IN_USE: prdata = mroe_pkg::PDATA_W'(order_q);
			default:                    prdata = '0;
		endcase
	end

	// An order above the store size acts as the store size.
	assign order_eff = (order_q > MAX_ORD4) ? MAX_ORD4 : order_q;

	mroe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mroe_dpath #(
		.MAX_ORDER (MAX_ORDER)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.order_eff     (order_eff),
		.operation     (in_ch.operation),
		.first_row     (in_ch.first_row),
		.second_row    (in_ch.second_row),
		.column_index  (in_ch.column_index),
		.scale_factor  (in_ch.scale_factor),
		.element_value (out_ch.element_value),
		.index_error   (out_ch.index_error)
	);

endmodule
